@@ sv/sbra_pkg.sv @@
// Shared types, codes and a helper function for the sector bitmap run allocator.
package sbra_pkg;

  localparam int DEF_MAP_BITS = 4096;
  localparam int DEF_MAX_RUN  = 256;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [23:0] start_sector;
    logic [8:0]  count;
  } sbra_in_t;

  typedef struct packed {
    logic [23:0] first_sector;
    logic [1:0]  status;
  } sbra_out_t;

  // Mask of the bits lo..hi of one map word, both ends included.
  function automatic logic [63:0] run_mask(input logic [5:0] lo, input logic [5:0] hi);
    logic [63:0] m_lo;
    logic [63:0] m_hi;
    m_lo = {64{1'b1}} << lo;
    m_hi = {64{1'b1}} >> (6'd63 - hi);
    return m_lo & m_hi;
  endfunction

endpackage

@@ sv/sbra_map_mem.sv @@
// Usage map storage: one write port and one registered read port.
module sbra_map_mem import sbra_pkg::*; #(
  parameter int DEPTH = DEF_MAP_BITS / 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sbra_ffz.sv @@
// Finds the lowest clear bit of one map word.
module sbra_ffz import sbra_pkg::*; (
  input  logic [63:0] word,
  output logic [5:0]  pos
);

  always_comb begin
    pos = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (!word[i]) begin
        pos = 6'(i);
      end
    end
  end

endmodule

@@ sv/sector_bitmap_run_allocator_core.sv @@
// Top level of the sector bitmap run allocator: control sequencer around the map memory.
//
// An item is a request: opcode (allocate or free), start sector and count. It is taken
// on a rising edge with start high and busy low; busy stays high while it is worked on
// and falls in the cycle in which its result is shown. Each item yields exactly one
// result, shown on out_data for a single cycle with out_valid high; the receiver cannot
// stall it and must take it in that cycle.
// An allocate scans the map one 64-bit word per cycle for the first clear bit, then
// checks the run and sets it, with a read state and an evaluate state for each map word
// touched in each of the two passes (a run of up to 256 bits touches at most 5 words).
// A free checks and clears the same way without the scan. A request with a bad count
// gives its result in the cycle after it is taken and leaves busy low; a free outside
// the map gives its result from the free check state, without reading the map. The map
// memory has a single, registered read port.
// The cfg channel writes first_data_sector and is always ready; the user must write it
// only while no item is in progress, as the block itself does not enforce this.
// After reset the block runs a clearing pass over the map, one word per cycle over all
// MAP_WORDS words, holding busy high; afterwards only bit zero is set.
module sector_bitmap_run_allocator_core import sbra_pkg::*; #(
  parameter int MAP_BITS = DEF_MAP_BITS,
  parameter int MAX_RUN  = DEF_MAX_RUN
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sbra_in_t  in_data,
  output logic      out_valid,
  output sbra_out_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(MAP_BITS + 512);
  localparam int WIW       = BW - 6;

  localparam logic [BW-1:0] MAP_BITS_B   = BW'(MAP_BITS);
  localparam logic [25:0]   MAP_BITS_F   = 26'(MAP_BITS);
  localparam logic [12:0]   MAX_RUN_C    = 13'(MAX_RUN);
  localparam logic [AW-1:0] LAST_WORD    = AW'(MAP_WORDS - 1);
  localparam logic [AW:0]   MAP_WORDS_S  = (AW + 1)'(MAP_WORDS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_ACHK  = 7'b0001000,
    S_FCHK  = 7'b0010000,
    S_RD    = 7'b0100000,
    S_EV    = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [23:0] fds_r, fds_nxt;
  sbra_in_t    req_r, req_nxt;
  logic [25:0] idx_r, idx_nxt;
  logic [AW:0] scan_addr_r, scan_addr_nxt;
  logic [AW-1:0] scan_word_r, scan_word_nxt;
  logic        scan_pend_r, scan_pend_nxt;
  logic [BW-1:0] run_b_r, run_b_nxt;
  logic [BW-1:0] end_r, end_nxt;
  logic [WIW-1:0] cur_r, cur_nxt;
  logic        phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  sbra_out_t   out_r, out_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;
  logic [5:0]    ffz_pos;

  logic          count_bad;
  logic [BW-1:0] alloc_sum;
  logic [25:0]   free_sum;
  logic [WIW-1:0] ws;
  logic [WIW-1:0] we;
  logic [5:0]    lo;
  logic [5:0]    hi;
  logic [63:0]   mask;
  logic          run_ok;

  sbra_map_mem #(.DEPTH(MAP_WORDS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sbra_ffz u_ffz (
    .word (mem_rdata),
    .pos  (ffz_pos)
  );

  assign count_bad = (in_data.count == 9'd0) || (13'(in_data.count) > MAX_RUN_C);
  assign alloc_sum = run_b_r + BW'(req_r.count);
  assign free_sum  = idx_r + 26'(req_r.count);
  assign ws        = run_b_r[BW-1:6];
  assign we        = end_r[BW-1:6];
  assign lo        = (cur_r == ws) ? run_b_r[5:0] : 6'd0;
  assign hi        = (cur_r == we) ? end_r[5:0] : 6'd63;
  assign mask      = run_mask(lo, hi);
  assign run_ok    = (req_r.opcode == OP_FREE) ? ((mem_rdata & mask) == mask)
                                                : ((mem_rdata & mask) == 64'd0);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    fds_nxt       = fds_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    scan_addr_nxt = scan_addr_r;
    scan_word_nxt = scan_word_r;
    scan_pend_nxt = scan_pend_r;
    run_b_nxt     = run_b_r;
    end_nxt       = end_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r[AW-1:0];
    mem_wdata     = 64'd0;
    mem_raddr     = cur_r[AW-1:0];

    if (cfg_valid) begin
      fds_nxt = cfg_data;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = (clr_addr_r == '0) ? 64'd1 : 64'd0;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          idx_nxt   = 26'(in_data.start_sector) - 26'(fds_r) + 26'd1;
          phase_nxt = 1'b0;
          if (count_bad) begin
            out_valid_nxt        = 1'b1;
            out_nxt.first_sector = 24'd0;
            out_nxt.status       = (in_data.opcode == OP_FREE) ? ST_NOT_ALLOC : ST_NO_ROOM;
          end else if (in_data.opcode == OP_ALLOC) begin
            scan_addr_nxt = '0;
            scan_pend_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        mem_raddr     = scan_addr_r[AW-1:0];
        scan_pend_nxt = scan_addr_r < MAP_WORDS_S;
        scan_word_nxt = scan_addr_r[AW-1:0];
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_pend_r && (mem_rdata != {64{1'b1}})) begin
          run_b_nxt = BW'({scan_word_r, ffz_pos});
          state_nxt = S_ACHK;
        end else if (scan_pend_r && (scan_word_r == LAST_WORD)) begin
          out_valid_nxt        = 1'b1;
          out_nxt.first_sector = 24'd0;
          out_nxt.status       = ST_NO_ROOM;
          state_nxt            = S_IDLE;
        end
      end
      S_ACHK: begin
        if ((run_b_r >= MAP_BITS_B) || (alloc_sum > MAP_BITS_B)) begin
          out_valid_nxt        = 1'b1;
          out_nxt.first_sector = 24'd0;
          out_nxt.status       = ST_NO_ROOM;
          state_nxt            = S_IDLE;
        end else begin
          end_nxt   = alloc_sum - 1'b1;
          cur_nxt   = run_b_r[BW-1:6];
          state_nxt = S_RD;
        end
      end
      S_FCHK: begin
        if (idx_r[25] || (free_sum > MAP_BITS_F)) begin
          out_valid_nxt        = 1'b1;
          out_nxt.first_sector = 24'd0;
          out_nxt.status       = ST_NOT_ALLOC;
          state_nxt            = S_IDLE;
        end else begin
          run_b_nxt = idx_r[BW-1:0];
          end_nxt   = free_sum[BW-1:0] - 1'b1;
          cur_nxt   = idx_r[BW-1:6];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!phase_r) begin
          if (!run_ok) begin
            out_valid_nxt        = 1'b1;
            out_nxt.first_sector = 24'd0;
            out_nxt.status       = (req_r.opcode == OP_FREE) ? ST_NOT_ALLOC : ST_NO_ROOM;
            state_nxt            = S_IDLE;
          end else if (cur_r == we) begin
            phase_nxt = 1'b1;
            cur_nxt   = ws;
            state_nxt = S_RD;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = (req_r.opcode == OP_FREE) ? (mem_rdata & ~mask) : (mem_rdata | mask);
          if (cur_r == we) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_OK;
            out_nxt.first_sector = (req_r.opcode == OP_FREE) ? 24'd0
                                   : (fds_r + 24'(run_b_r) - 24'd1);
            state_nxt            = S_IDLE;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      fds_r       <= 24'd0;
      scan_pend_r <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fds_r       <= fds_nxt;
      scan_pend_r <= scan_pend_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    idx_r       <= idx_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_word_r <= scan_word_nxt;
    run_b_r     <= run_b_nxt;
    end_r       <= end_nxt;
    cur_r       <= cur_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
